[rtl/core/i2cbm_pkg.sv]
// Shared types, codes and constants of the I2C bit-level master.
package i2cbm_pkg;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_SACK  = 3'd5,
    OP_RACK  = 3'd6
  } op_e;

  localparam int unsigned CFG_W       = 16;
  localparam logic [15:0] HOLD_RESET  = 16'd50;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  // Word on the input port.
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data_byte;
    logic       ack_level;
    logic       sda_in;
  } in_t;

  // Word on the result port.
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_seen;
    logic       rejected;
  } out_t;

  // Classified word carried from the front to the back.
  typedef struct packed {
    op_e        op;
    logic [7:0] data_byte;
    logic       ack_level;
    logic       sda_in;
  } item_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Number of line steps in a command sequence.
  function automatic logic [4:0] step_total(input op_e op);
    logic [4:0] n;
    case (op)
      OP_START: n = 5'd4;
      OP_STOP:  n = 5'd3;
      OP_WRITE: n = 5'd24;
      OP_READ:  n = 5'd25;
      OP_SACK:  n = 5'd3;
      OP_RACK:  n = 5'd4;
      default:  n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

[rtl/core/i2cbm_front.sv]
// Front stage: accept input words, classify the op and hand them to the queue.
module i2cbm_front import i2cbm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_t       in_word_i,
  input  q_status_t q_status_i,
  output logic      push_o,
  output item_t     push_item_o
);

  logic  slot_valid_q, slot_valid_d;
  item_t slot_q, slot_d;
  logic  accept;

  assign push_o      = slot_valid_q && !q_status_i.full;
  assign in_stall_o  = slot_valid_q && q_status_i.full;
  assign accept      = in_valid_i && !in_stall_o;
  assign push_item_o = slot_q;

  always_comb begin
    slot_valid_d = slot_valid_q;
    slot_d       = slot_q;
    if (push_o) begin
      slot_valid_d = 1'b0;
    end
    if (accept) begin
      slot_valid_d     = 1'b1;
      slot_d.data_byte = in_word_i.data_byte;
      slot_d.ack_level = in_word_i.ack_level;
      slot_d.sda_in    = in_word_i.sda_in;
      // Undefined op codes count as ticks.
      if (in_word_i.op inside {[OP_START:OP_RACK]}) begin
        slot_d.op = op_e'(in_word_i.op);
      end else begin
        slot_d.op = OP_TICK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= 1'b0;
    end else begin
      slot_valid_q <= slot_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

[rtl/core/i2cbm_queue.sv]
// Short queue between the front and the back stage.
module i2cbm_queue import i2cbm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  item_t     push_item_i,
  input  logic      pop_i,
  output item_t     pop_item_o,
  output q_status_t status_o
);

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  assign status_o.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign pop_item_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full || pop_i)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

[rtl/core/i2cbm_back.sv]
// Back stage: line sequencer, hold counter and result register.
module i2cbm_back import i2cbm_pkg::*; #(
  parameter int unsigned HOLD_COUNT_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  q_status_t        q_status_i,
  input  item_t            item_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_word_o
);

  localparam int unsigned HCB = HOLD_COUNT_BITS;

  logic [CFG_W-1:0] cfg_q;
  logic [HCB-1:0]   hold_sat, hold_load;

  op_e            active_q, active_d;
  logic [4:0]     step_q, step_d, step_inc;
  logic [1:0]     phase_q, phase_d;
  logic [HCB-1:0] cnt_q, cnt_d, cnt_dec;
  logic           scl_q, scl_d, sda_q, sda_d, ack_q, ack_d;
  logic [7:0]     shift_q, shift_d, shift_base, rx_q, rx_d;
  logic           done, rej, do_apply;
  logic           out_valid_q;
  out_t           out_q, out_d;

  // Saturate the programmed hold to the counter range; zero acts as one.
  if (HCB >= CFG_W) begin : g_wide
    assign hold_sat = HCB'(cfg_q);
  end else begin : g_narrow
    assign hold_sat = (|cfg_q[CFG_W-1:HCB]) ? '1 : cfg_q[HCB-1:0];
  end
  assign hold_load = (hold_sat == '0) ? HCB'(1) : hold_sat;

  assign pop_o       = !q_status_i.empty && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign cnt_dec     = cnt_q - ((cnt_q != '0) ? HCB'(1) : HCB'(0));
  assign step_inc    = step_q + 5'd1;

  always_comb begin
    active_d   = active_q;
    step_d     = step_q;
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    scl_d      = scl_q;
    sda_d      = sda_q;
    ack_d      = ack_q;
    rx_d       = rx_q;
    shift_base = shift_q;
    done       = 1'b0;
    rej        = 1'b0;
    do_apply   = 1'b0;
    if (pop_o) begin
      if (item_i.op != OP_TICK) begin
        if (active_q != OP_TICK) begin
          rej = 1'b1;
        end else begin
          active_d = item_i.op;
          step_d   = '0;
          phase_d  = '0;
          do_apply = 1'b1;
          case (item_i.op)
            OP_WRITE: shift_base = item_i.data_byte;
            OP_SACK:  shift_base = {7'd0, item_i.ack_level};
            OP_READ:  shift_base = '0;
            default:  ;
          endcase
        end
      end else if (active_q != OP_TICK) begin
        cnt_d = cnt_dec;
        if (cnt_dec == '0) begin
          if (step_inc >= step_total(active_q)) begin
            if (active_q == OP_READ) begin
              rx_d = shift_q;
            end
            active_d = OP_TICK;
            step_d   = '0;
            phase_d  = '0;
            done     = 1'b1;
          end else begin
            step_d   = step_inc;
            do_apply = 1'b1;
            // The read opens with one extra step before its bit cycles.
            if ((active_q == OP_READ && step_q == '0) || phase_q == 2'd2) begin
              phase_d = '0;
            end else begin
              phase_d = phase_q + 2'd1;
            end
          end
        end
      end
    end

    shift_d = shift_base;
    if (do_apply) begin
      cnt_d = hold_load;
      case (active_d)
        OP_START: begin
          case (step_d[1:0])
            2'd0:    sda_d = 1'b1;
            2'd1:    scl_d = 1'b1;
            2'd2:    sda_d = 1'b0;
            default: scl_d = 1'b0;
          endcase
        end
        OP_STOP: begin
          case (step_d[1:0])
            2'd0:    sda_d = 1'b0;
            2'd1:    scl_d = 1'b1;
            default: sda_d = 1'b1;
          endcase
        end
        OP_WRITE: begin
          case (phase_d)
            2'd0: begin
              sda_d   = shift_base[7];
              shift_d = {shift_base[6:0], 1'b0};
            end
            2'd1:    scl_d = 1'b1;
            default: scl_d = 1'b0;
          endcase
        end
        OP_READ: begin
          if (step_d == '0) begin
            sda_d = 1'b1;
          end else begin
            case (phase_d)
              2'd0:    scl_d = 1'b1;
              2'd1:    shift_d = {shift_base[6:0], item_i.sda_in};
              default: scl_d = 1'b0;
            endcase
          end
        end
        OP_SACK: begin
          case (step_d[1:0])
            2'd0:    sda_d = shift_base[0];
            2'd1:    scl_d = 1'b1;
            default: scl_d = 1'b0;
          endcase
        end
        OP_RACK: begin
          case (step_d[1:0])
            2'd0:    sda_d = 1'b1;
            2'd1:    scl_d = 1'b1;
            2'd2:    ack_d = item_i.sda_in;
            default: scl_d = 1'b0;
          endcase
        end
        default: ;
      endcase
    end

    out_d.scl_out   = scl_d;
    out_d.sda_out   = sda_d;
    out_d.busy_res  = (active_d != OP_TICK);
    out_d.done_res  = done;
    out_d.read_data = rx_d;
    out_d.ack_seen  = ack_d;
    out_d.rejected  = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= HOLD_RESET;
      active_q    <= OP_TICK;
      step_q      <= '0;
      phase_q     <= '0;
      cnt_q       <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      ack_q       <= 1'b1;
      shift_q     <= '0;
      rx_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      active_q <= active_d;
      step_q   <= step_d;
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      scl_q    <= scl_d;
      sda_q    <= sda_d;
      ack_q    <= ack_d;
      shift_q  <= shift_d;
      rx_q     <= rx_d;
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.done_res |-> !out_q.busy_res)
    else $error("done reported while still busy");
  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.rejected |-> out_q.busy_res && !out_q.done_res)
    else $error("reject reported outside a busy sequence");
  a_hold_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q != OP_TICK |-> cnt_q != '0)
    else $error("hold counter empty during a sequence");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q != OP_TICK |-> step_q < step_total(active_q))
    else $error("step index past end of sequence");

endmodule

[rtl/core/i2c_bit_level_master_top.sv]
// An accepted word passes the front slot, the queue and the result register in turn.
// Throughput: one word per cycle unless results stall; each word updates all state.
// The queue (four words) lets the input side keep flowing while results stall.
// Reset (rst_ni low, asynchronous): idle, SCL and SDA released, hold_ticks 50,
// read byte zero, ack flag one, queue and result register empty.
// Configuration is a single write-only register, hold_ticks.
module i2c_bit_level_master_top import i2cbm_pkg::*; #(
  parameter int unsigned HOLD_COUNT_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Configuration: hold_ticks
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  // Input words: commands and ticks
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_t              in_word_i,
  // Result words: one per input word
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_word_o
);

  // Front to queue
  logic      push;
  item_t     push_item;
  // Queue to back
  logic      pop;
  item_t     pop_item;
  q_status_t q_status;

  // Classify each word (command or tick) and register it.
  i2cbm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_item_o (push_item)
  );

  // Decouple the front from the sequencer so each side can stall on its own.
  i2cbm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .status_o    (q_status)
  );

  // Run the line sequence: one word advances the sequencer by at most one step.
  i2cbm_back #(
    .HOLD_COUNT_BITS (HOLD_COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_status_i  (q_status),
    .item_i      (pop_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

[dv/i2cbm_line_checker.sv]
`timescale 1ns / 100ps
// Predictor and result checker for the I2C bit-level master line sequencer.
module i2cbm_line_checker import i2cbm_pkg::*; #(
  parameter int unsigned HOLD_COUNT_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  in_t              in_word_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  out_t             out_word_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o,
  output logic             seq_busy_o
);

  logic [CFG_W-1:0] hold_cfg;
  op_e              cur_cmd;     // OP_TICK stands for idle
  logic [4:0]       step_idx;
  logic [31:0]      hold_left;
  logic             scl_q;
  logic             sda_q;
  logic             ack_q;
  logic [7:0]       shift_q;
  logic [7:0]       rx_byte_q;
  out_t             line_q[$];
  out_t             want;
  int unsigned      fails;

  function automatic int unsigned seq_length(input op_e c);
    case (c)
      OP_START: return 4;
      OP_STOP:  return 3;
      OP_WRITE: return 24;
      OP_READ:  return 25;
      OP_SACK:  return 3;
      OP_RACK:  return 4;
      default:  return 0;
    endcase
  endfunction

  // Zero holds for one tick; values beyond the counter width clip to its maximum.
  function automatic logic [31:0] hold_reload();
    logic [63:0] lim;
    logic [63:0] v;
    lim = (64'd1 << HOLD_COUNT_BITS) - 64'd1;
    v   = 64'(hold_cfg);
    if (v > lim) v = lim;
    if (v == 64'd0) v = 64'd1;
    return v[31:0];
  endfunction

  function automatic void apply_step(input logic sda);
    int unsigned bit_no;
    int unsigned phase;
    case (cur_cmd)
      OP_START: begin
        case (step_idx)
          5'd0:    sda_q = 1'b1;
          5'd1:    scl_q = 1'b1;
          5'd2:    sda_q = 1'b0;
          default: scl_q = 1'b0;
        endcase
      end
      OP_STOP: begin
        case (step_idx)
          5'd0:    sda_q = 1'b0;
          5'd1:    scl_q = 1'b1;
          default: sda_q = 1'b1;
        endcase
      end
      OP_WRITE: begin
        bit_no = step_idx / 3;
        phase  = step_idx % 3;
        if (phase == 0) sda_q = shift_q[7 - bit_no];
        else if (phase == 1) scl_q = 1'b1;
        else scl_q = 1'b0;
      end
      OP_READ: begin
        if (step_idx == 5'd0) begin
          sda_q = 1'b1;
        end else begin
          phase = (step_idx - 1) % 3;
          if (phase == 0) scl_q = 1'b1;
          else if (phase == 1) shift_q = {shift_q[6:0], sda};
          else scl_q = 1'b0;
        end
      end
      OP_SACK: begin
        case (step_idx)
          5'd0:    sda_q = shift_q[0];
          5'd1:    scl_q = 1'b1;
          default: scl_q = 1'b0;
        endcase
      end
      OP_RACK: begin
        case (step_idx)
          5'd0:    sda_q = 1'b1;
          5'd1:    scl_q = 1'b1;
          5'd2:    ack_q = sda;
          default: scl_q = 1'b0;
        endcase
      end
      default: ;
    endcase
  endfunction

  function automatic out_t predict(input in_t w);
    out_t r;
    r = '0;
    if (w.op >= OP_START && w.op <= OP_RACK) begin
      // A command while busy leaves the sequence untouched.
      if (cur_cmd != OP_TICK) begin
        r.rejected = 1'b1;
      end else begin
        cur_cmd  = op_e'(w.op);
        step_idx = '0;
        case (cur_cmd)
          OP_WRITE: shift_q = w.data_byte;
          OP_SACK:  shift_q = {7'd0, w.ack_level};
          OP_READ:  shift_q = '0;
          default: ;
        endcase
        apply_step(w.sda_in);
        hold_left = hold_reload();
      end
    end else if (cur_cmd != OP_TICK) begin
      if (hold_left != 32'd0) hold_left--;
      if (hold_left == 32'd0) begin
        step_idx++;
        if (step_idx >= seq_length(cur_cmd)) begin
          if (cur_cmd == OP_READ) rx_byte_q = shift_q;
          cur_cmd    = OP_TICK;
          step_idx   = '0;
          r.done_res = 1'b1;
        end else begin
          apply_step(w.sda_in);
          hold_left = hold_reload();
        end
      end
    end
    r.scl_out   = scl_q;
    r.sda_out   = sda_q;
    r.busy_res  = (cur_cmd != OP_TICK);
    r.read_data = rx_byte_q;
    r.ack_seen  = ack_q;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_val,
                                      input int unsigned act_val);
    if (exp_val != act_val) begin
      fails++;
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
    end
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_cfg  = HOLD_RESET;
      cur_cmd   = OP_TICK;
      step_idx  = '0;
      hold_left = '0;
      scl_q     = 1'b1;
      sda_q     = 1'b1;
      ack_q     = 1'b1;
      shift_q   = '0;
      rx_byte_q = '0;
      fails     = 0;
      line_q.delete();
    end else begin
      if (cfg_we_i) hold_cfg = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (line_q.size() == 0) begin
          fails++;
          $error("result word with no prediction waiting");
        end else begin
          want = line_q.pop_front();
          check_field("scl_out", 32'(want.scl_out), 32'(out_word_i.scl_out));
          check_field("sda_out", 32'(want.sda_out), 32'(out_word_i.sda_out));
          check_field("busy_res", 32'(want.busy_res), 32'(out_word_i.busy_res));
          check_field("done_res", 32'(want.done_res), 32'(out_word_i.done_res));
          check_field("read_data", 32'(want.read_data), 32'(out_word_i.read_data));
          check_field("ack_seen", 32'(want.ack_seen), 32'(out_word_i.ack_seen));
          check_field("rejected", 32'(want.rejected), 32'(out_word_i.rejected));
        end
      end
      if (in_valid_i && !in_stall_i) line_q.push_back(predict(in_word_i));
    end
    fail_count_o <= fails;
    pending_o    <= 32'(line_q.size());
    seq_busy_o   <= (cur_cmd != OP_TICK);
  end

endmodule

[dv/i2c_bit_level_master_top_test.sv]
`timescale 1ns / 100ps
// Testbench top for the I2C bit-level master: stimulus, handshake pacing and verdict.
module i2c_bit_level_master_top_test;
  import i2cbm_pkg::*;

  // Hold counter at the block's default width.
  localparam int unsigned HOLD_BITS   = 16;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned PHASE_WORDS = 90;
  localparam int unsigned RAND_PHASES = 5;
  localparam logic [2:0]  OP_UNDEF    = 3'd7;  // unassigned code, decodes as a tick

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;
  typedef enum logic [1:0] {SDA_RANDOM, SDA_LOW, SDA_HIGH} sda_mode_e;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_t              in_word_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_t             out_word_o;

  int unsigned      fail_count;
  int unsigned      words_pending;
  logic             seq_busy;

  int unsigned      burst_left  = 0;
  sda_mode_e        sda_mode    = SDA_RANDOM;
  rx_mode_e         rx_mode     = RX_FREE;
  logic [7:0]       rx_cycle    = '0;
  op_e              cmd_ops[6]  = '{OP_START, OP_STOP, OP_WRITE, OP_READ, OP_SACK, OP_RACK};

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  i2c_bit_level_master_top #(
    .HOLD_COUNT_BITS(HOLD_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // Watch both channels beside the block; predict and compare every result word.
  i2cbm_line_checker #(
    .HOLD_COUNT_BITS(HOLD_BITS)
  ) line_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_word_i    (in_word_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_i   (out_word_o),
    .fail_count_o (fail_count),
    .pending_o    (words_pending),
    .seq_busy_o   (seq_busy)
  );

  // Result side: each time the cycle counter wraps, pick a new stall style - none,
  // light, heavy, or a fixed periodic pattern of stall bursts from the cycle counter.
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 8'd1;
    if (rx_cycle == 8'd0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_FREE:  out_stall_i <= 1'b0;
      RX_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:  out_stall_i <= (rx_cycle[4:2] == 3'b111);
    endcase
  end

  // Drop out when neither channel moves a word for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic in_t word_of(input logic [2:0] op, input logic [7:0] data,
                                  input logic ack, input logic sda);
    in_t w;
    w.op        = op;
    w.data_byte = data;
    w.ack_level = ack;
    w.sda_in    = sda;
    return w;
  endfunction

  // SDA level the bus shows on a tick, following the current read pattern.
  function automatic logic line_bit();
    case (sda_mode)
      SDA_LOW:  return 1'b0;
      SDA_HIGH: return 1'b1;
      default:  return 1'($urandom);
    endcase
  endfunction

  // Offer one word and hold it until accepted. Between bursts of random length,
  // drop valid for a random gap; long bursts leave stretches with no idling.
  task automatic send_word(input in_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 3);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 16);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
  endtask

  task automatic send_tick();
    send_word(word_of(($urandom_range(0, 7) == 0) ? OP_UNDEF : OP_TICK,
                      8'($urandom), 1'($urandom), line_bit()));
  endtask

  task automatic issue(input op_e op, input logic [7:0] data, input logic ack);
    send_word(word_of(op, data, ack, 1'($urandom)));
  endtask

  // Tick until the sequence ends. The busy flag trails by one word, so at least
  // one tick always goes out and one spare tick lands on the idle block.
  task automatic run_to_idle();
    do send_tick(); while (seq_busy);
  endtask

  // Change hold_ticks only with nothing in flight and the sequencer idle.
  task automatic set_hold(input logic [CFG_W-1:0] value);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (words_pending != 0 || seq_busy);
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned taken;
    logic        after_cmd;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Idle ticks, the unassigned code among them, change nothing.
    send_word(word_of(OP_TICK, 8'hFF, 1'b1, 1'b1));
    send_word(word_of(OP_UNDEF, 8'h00, 1'b0, 1'b0));

    // Reset hold of 50: a start, a stop refused mid-sequence, then run it out.
    issue(OP_START, 8'h00, 1'b0);
    issue(OP_STOP, 8'hFF, 1'b1);
    send_word(word_of(OP_UNDEF, 8'h00, 1'b0, 1'b1));
    run_to_idle();

    // Single-tick hold: every command but start, byte extremes, reads of all ones and all zeros.
    set_hold(16'd1);
    issue(OP_WRITE, 8'hFF, 1'b0);
    run_to_idle();
    issue(OP_WRITE, 8'h00, 1'b1);
    run_to_idle();
    sda_mode = SDA_HIGH;
    issue(OP_READ, 8'h00, 1'b0);
    run_to_idle();
    sda_mode = SDA_LOW;
    issue(OP_READ, 8'hFF, 1'b1);
    run_to_idle();
    issue(OP_RACK, 8'h00, 1'b1);
    run_to_idle();
    sda_mode = SDA_HIGH;
    issue(OP_RACK, 8'hFF, 1'b0);
    run_to_idle();
    sda_mode = SDA_RANDOM;
    issue(OP_SACK, 8'hFF, 1'b0);
    run_to_idle();
    issue(OP_SACK, 8'h00, 1'b1);
    run_to_idle();
    issue(OP_STOP, 8'h00, 1'b0);
    run_to_idle();

    // Refuse every command while a write is in progress.
    issue(OP_WRITE, 8'hA5, 1'b0);
    foreach (cmd_ops[k]) issue(cmd_ops[k], 8'($urandom), 1'($urandom));
    run_to_idle();

    // Zero hold acts as one tick.
    set_hold(16'd0);
    issue(OP_READ, 8'h00, 1'b0);
    run_to_idle();
    issue(OP_WRITE, 8'h5A, 1'b1);
    run_to_idle();

    // Long hold: a stop held 100 ticks per step, with a command refused on the way.
    set_hold(16'd100);
    issue(OP_STOP, 8'h00, 1'b0);
    issue(OP_RACK, 8'hFF, 1'b1);
    run_to_idle();

    // Random part: mostly complete command sequences with random content,
    // plus stray commands while busy and idle ticks as noise.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      set_hold((ph == 0) ? 16'd2 : 16'($urandom_range(1, 5)));
      taken     = 0;
      after_cmd = 1'b0;
      while (taken < PHASE_WORDS) begin
        if (seq_busy || after_cmd) begin
          after_cmd = 1'b0;
          if ($urandom_range(0, 99) < 8) begin
            issue(cmd_ops[$urandom_range(0, 5)], 8'($urandom), 1'($urandom));
          end else begin
            send_tick();
            taken++;
          end
        end else if ($urandom_range(0, 99) < 80) begin
          sda_mode = sda_mode_e'($urandom_range(0, 2));
          issue(cmd_ops[$urandom_range(0, 5)], 8'($urandom), 1'($urandom));
          taken++;
          after_cmd = 1'b1;
        end else begin
          send_tick();
        end
      end
      run_to_idle();
    end

    // Drain: wait out every prediction, then the pipeline latency.
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (words_pending != 0);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[i2c_bit_level_master_top.f]
rtl/core/i2cbm_pkg.sv
rtl/core/i2cbm_front.sv
rtl/core/i2cbm_queue.sv
rtl/core/i2cbm_back.sv
rtl/core/i2c_bit_level_master_top.sv
dv/i2cbm_line_checker.sv
dv/i2c_bit_level_master_top_test.sv
